>>> sv/assert_macros.svh
// Assertion macros shared by the integer-to-ASCII RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/itoa_pkg.sv
// Shared types, character codes and digit helper for the integer-to-ASCII block.
package itoa_pkg;

   localparam int DIV_BITS = 8;   // quotient bits resolved per divider cycle

   localparam logic [5:0] RADIX_MIN = 6'd2;
   localparam logic [5:0] RADIX_MAX = 6'd36;
   localparam logic [5:0] RADIX_DEC = 6'd10;

   localparam logic [6:0] CH_ZERO    = 7'd48;
   localparam logic [6:0] CH_LOWER_A = 7'd97;
   localparam logic [6:0] CH_MINUS   = 7'd45;
   localparam logic [6:0] DIGIT_NINE = 7'd9;
   localparam logic [6:0] DIGIT_TEN  = 7'd10;

   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic emit_sign;
      logic rd_en;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic q_zero;
      logic neg;
      logic cnt_zero;
      logic out_free;
   } status_type;

   function automatic logic [6:0] digit_char(input logic [5:0] d);
      logic [6:0] dw;
      dw = {1'b0, d};
      if (dw > DIGIT_NINE) begin
         return (dw - DIGIT_TEN) + CH_LOWER_A;
      end
      return dw + CH_ZERO;
   endfunction

endpackage

>>> sv/itoa_dp.sv
// Datapath: radix divider, digit stack and output word register.
`include "assert_macros.svh"
module itoa_dp
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [5:0]            req_radix,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_character,
   output logic                  rsp_last
);

   localparam int PAD_BITS = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int CW = $clog2(VALUE_BITS + 1);
   localparam int AW = $clog2(VALUE_BITS);

   logic [PAD_BITS-1:0] q_ff, q_in;
   logic [5:0]          rem_ff, rem_in;
   logic [5:0]          radix_ff, radix_in;
   logic                neg_ff, neg_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [5:0]          rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [6:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [5:0] digit_mem [VALUE_BITS];

   logic [5:0]            radix_clamp;
   logic                  load_neg;
   logic [VALUE_BITS-1:0] load_mag;
   logic [6:0]            rem_w;
   logic [PAD_BITS-1:0]   q_w;
   logic [CW-1:0]         cnt_dec;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic                  out_free;
   logic                  char_legal;

   // input conditioning
   always_comb begin
      if (req_radix < RADIX_MIN) begin
         radix_clamp = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_clamp = RADIX_MAX;
      end else begin
         radix_clamp = req_radix;
      end
      load_neg = (radix_clamp == RADIX_DEC) && req_value[VALUE_BITS-1];
      load_mag = load_neg ? (~req_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : req_value;
   end

   // restoring division, DIV_BITS quotient bits per cycle
   always_comb begin
      rem_w = {1'b0, rem_ff};
      q_w   = q_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         rem_w = {rem_w[5:0], q_w[PAD_BITS-1]};
         q_w   = {q_w[PAD_BITS-2:0], 1'b0};
         if (rem_w >= {1'b0, radix_ff}) begin
            rem_w   = rem_w - {1'b0, radix_ff};
            q_w[0]  = 1'b1;
         end
      end
   end

   assign cnt_dec  = cnt_ff - CW'(1);
   assign rd_addr  = cnt_dec[AW-1:0];
   assign wr_addr  = cnt_ff[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      q_in     = q_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         q_in     = PAD_BITS'(load_mag);
         rem_in   = '0;
         radix_in = radix_clamp;
         neg_in   = load_neg;
         cnt_in   = '0;
      end else if (cmd.div_step) begin
         q_in   = q_w;
         rem_in = rem_w[5:0];
      end else if (cmd.push) begin
         rem_in = '0;
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.rd_en) begin
         cnt_in = cnt_dec;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CH_MINUS;
         rsp_last_in  = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = digit_char(rd_data_ff);
         rsp_last_in  = (cnt_ff == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit stack, least significant digit pushed first
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         digit_mem[wr_addr] <= rem_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   assign status.q_zero   = (q_ff == '0);
   assign status.neg      = neg_ff;
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.out_free = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // minus, '0'..'9' or 'a'..'z'
   assign char_legal = (rsp_char_ff == CH_MINUS)
                    || ((rsp_char_ff >= CH_ZERO) && (rsp_char_ff <= 7'd57))
                    || ((rsp_char_ff >= CH_LOWER_A) && (rsp_char_ff <= 7'd122));

   `ASSERT_IMPL(a_push_fits, clock, reset, cmd.push, cnt_ff < CW'(VALUE_BITS))
   `ASSERT_IMPL(a_char_legal, clock, reset, rsp_valid_ff, char_legal)
   `ASSERT_NEXT(a_last_digit, clock, reset, cmd.emit_digit && (cnt_ff == '0), rsp_valid_ff && rsp_last_ff)

endmodule

>>> sv/itoa_ctrl.sv
// Controller: sequences load, division, digit push and character output.
`include "assert_macros.svh"
module itoa_ctrl
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
   localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_PUSH  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_FETCH = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_PUSH;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = status.q_zero ? ST_SIGN : ST_DIV;
         end
         ST_SIGN: begin
            if (!status.neg) begin
               state_in = ST_READ;
            end else if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_FETCH;
         end
         ST_FETCH: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               state_in       = status.cnt_zero ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `ASSERT_IMPL(a_read_nonempty, clock, reset, state_ff == ST_READ, !status.cnt_zero)
   `ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit_sign || cmd.emit_digit, status.out_free)

endmodule

>>> sv/integer_to_ascii_radix.sv
// Top level: integer to ASCII text in a base from 2 to 36.
//
//  channel | direction | ports                              | word
//  req     | in        | req_valid/ready, value, radix      | one integer + base
//  rsp     | out       | rsp_valid/ready, character, last   | one ASCII character
//
// Sequence: a load; per digit, divider steps over the whole quotient, then a
//   push (8 quotient bits per divider cycle); a sign state, minus sent
//   only when negative; per character a stack read, then a registered read.
// One word is worked at a time; req_ready is high only between words.
// Reset (synchronous, active high) clears controller state and output valid.
// rsp stalls hold the output register and pause the character readout only.
module integer_to_ascii_radix
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [5:0]            req_radix,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [6:0]            rsp_character,
   output logic                  rsp_last
);

   cmd_type    cmd;
   status_type status;

   // controller: owns the sequence and divider step count
   itoa_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: radix clamp, base-10 sign handling, divider, digit stack, output reg
   itoa_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

>>> verif/tb_integer_to_ascii_radix.sv
// Testbench for integer_to_ascii_radix: digit strings of 32-bit words checked per character.
module tb_integer_to_ascii_radix;
   import itoa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VBITS       = 32;
   localparam int RESET_TICKS = 8;
   localparam int STALL_LIMIT = 4000;  // idle cycles before the watchdog trips
   localparam int DRAIN_TICKS = 600;   // > one worst-case word without stalls (base 2)
   localparam int RANDOM_WORDS = 206;
   localparam int PRINT_CAP   = 30;

   typedef struct packed {
      logic [6:0] glyph;
      logic       last;
   } glyph_type;

   // Expected-character store plus the predictor that fills it.
   class digit_string_checker;
      glyph_type glyphs_due[$];
      int     errors;
      int     words;
      int     chars;
      int     neg_decimal;
      int     clamped;

      function new();
         errors = 0;
         words = 0;
         chars = 0;
         neg_decimal = 0;
         clamped = 0;
      endfunction

      task report(input string what);
         if (errors < PRINT_CAP) begin
            $display("%0t mismatch: %s", $realtime, what);
         end
         errors++;
      endtask

      function logic [6:0] glyph_of(input logic [5:0] d);
         if (d < RADIX_DEC) begin
            return CH_ZERO + {1'b0, d};
         end
         return CH_LOWER_A + {1'b0, d} - {1'b0, RADIX_DEC};
      endfunction

      // Spell one accepted word into the store, most significant first.
      function void note_word(input logic [VBITS-1:0] value, input logic [5:0] radix);
         logic [5:0]       base;
         logic [VBITS-1:0] mag;
         logic [6:0]       text[$];
         glyph_type        g;
         base = radix;
         if (base < RADIX_MIN) begin
            base = RADIX_MIN;
         end
         if (base > RADIX_MAX) begin
            base = RADIX_MAX;
         end
         if (base != radix) begin
            clamped++;
         end
         mag = value;
         // only base ten is signed; every other base reads the raw bits
         if (base == RADIX_DEC && value[VBITS-1]) begin
            mag = -value;
            neg_decimal++;
         end
         do begin
            text.push_front(glyph_of(6'(mag % base)));
            mag = mag / base;
         end while (mag != 0);
         if (base == RADIX_DEC && value[VBITS-1]) begin
            text.push_front(CH_MINUS);
         end
         foreach (text[i]) begin
            g.glyph = text[i];
            g.last  = (i == text.size() - 1);
            glyphs_due.push_back(g);
         end
         words++;
      endfunction

      function int pending();
         return glyphs_due.size();
      endfunction

      task check_char(input logic [6:0] glyph, input logic last);
         glyph_type want;
         chars++;
         if (glyphs_due.size() == 0) begin
            report($sformatf("unexpected character 0x%02h last=%0b", glyph, last));
         end else begin
            want = glyphs_due.pop_front();
            if (glyph !== want.glyph) begin
               report($sformatf("char %0d: character 0x%02h, want 0x%02h",
                                chars, glyph, want.glyph));
            end
            if (last !== want.last) begin
               report($sformatf("char %0d: last %0b, want %0b", chars, last, want.last));
            end
         end
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [VBITS-1:0] req_value = '0;
   logic [5:0]       req_radix = RADIX_DEC;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [6:0]       rsp_character;
   logic             rsp_last;

   digit_string_checker sb = new();

   int unsigned idle_ticks = 0;
   int unsigned burst_left = 0;
   // receiver pacing: a mode held for a random phase, see below
   int unsigned rx_mode = 0;
   int unsigned rx_left = 0;
   int unsigned rx_tick = 0;

   always #10 clock = ~clock;

   integer_to_ascii_radix #(
      .VALUE_BITS(VBITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // Monitor: both channels sampled at the edge, before this edge's updates land.
   // The watchdog counts edges with no word moving on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_word(req_value, req_radix);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_char(rsp_character, rsp_last);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_ticks <= 0;
         end else begin
            idle_ticks <= idle_ticks + 1;
         end
         if (idle_ticks >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d chars outstanding",
                     idle_ticks, sb.pending());
            $display("[integer_to_ascii_radix] ERROR");
            $finish;
         end
      end
   end

   // Receiver: each phase picks a mode - always ready, coin flip, one edge in eight,
   // or mostly ready - so stalls land on sign, digit and last characters alike.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_left <= $urandom_range(20, 150);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= (rx_tick[2:0] == 3'd0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // Offer one word and hold it until the block takes it; then pace the sender.
   task automatic send_word(input logic [VBITS-1:0] value, input logic [5:0] radix);
      int unsigned gap;
      req_value <= value;
      req_radix <= radix;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      // burst bookkeeping: gap only when a burst runs out
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(0, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Random word: value classes reach both ends of the range; radix is mostly
   // legal, often ten for the signed path, sometimes anything the six bits hold.
   task automatic random_word(output logic [VBITS-1:0] value, output logic [5:0] radix);
      case ($urandom_range(0, 7))
         0, 1, 2: value = $urandom();
         3:       value = $urandom_range(0, 99);
         4:       value = -$urandom_range(1, 5000);
         5:       value = 32'h8000_0000 ^ $urandom_range(0, 3);
         6:       value = 32'd1 << $urandom_range(0, 31);
         default: value = ~$urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: radix = 6'($urandom_range(RADIX_MIN, RADIX_MAX));
         6, 7:             radix = RADIX_DEC;
         8:                radix = $urandom_range(0, 1) ? 6'd16 : RADIX_MIN;
         default:          radix = 6'($urandom_range(0, 63));
      endcase
   endtask

   initial begin
      logic [VBITS-1:0] v;
      logic [5:0]       r;

      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero, extremes of both signs, most negative in base ten,
      // negatives read unsigned elsewhere, letter digits, clamped radix.
      send_word(32'd0, RADIX_DEC);
      send_word(32'd0, RADIX_MIN);
      send_word(32'h7fff_ffff, RADIX_DEC);
      send_word(32'h8000_0000, RADIX_DEC);
      send_word(32'hffff_ffff, RADIX_DEC);
      send_word(32'hffff_ffff, RADIX_MIN);
      send_word(32'hffff_ffff, 6'd16);
      send_word(32'h8000_0000, RADIX_MIN);
      send_word(32'hffff_ffff, RADIX_MAX);
      send_word(32'd35, RADIX_MAX);
      send_word(32'd12345, RADIX_MAX);
      send_word(32'd9, RADIX_DEC);
      send_word(32'd10, 6'd11);
      send_word(32'd5, 6'd0);
      send_word(32'd5, 6'd1);
      send_word(32'd35, 6'd37);
      send_word(32'd35, 6'd63);
      send_word(32'd255, 6'd16);
      send_word(-32'd42, 6'd8);
      send_word(-32'd42, RADIX_DEC);
      send_word(32'd1, 6'd3);
      send_word(32'd123456789, 6'd7);
      send_word(32'h5555_5555, RADIX_MIN);
      send_word(32'haaaa_aaaa, 6'd4);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         random_word(v, r);
         send_word(v, r);
      end
      req_valid <= 1'b0;

      // watchdog bounds this wait if characters stop coming
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      // stray characters after the last expected one still get flagged
      repeat (DRAIN_TICKS) @(posedge clock);

      $display("covered %0d words, %0d characters: %0d negative decimal, %0d clamped radix",
               sb.words, sb.chars, sb.neg_decimal, sb.clamped);
      $display("%0d mismatches, %0d characters still expected", sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[integer_to_ascii_radix] OK");
      end else begin
         $display("[integer_to_ascii_radix] ERROR");
      end
      $finish;
   end

endmodule
